@@ sv/msqm_pkg.sv @@
// ----------------------------------------------------------------------------
// Multi stack/queue manager package
// Shared command, result and control types of the list manager.
// ----------------------------------------------------------------------------
package msqm_pkg;

	typedef enum logic [1:0] {
		OP_CREATE = 2'd0,
		OP_PUSH   = 2'd1,
		OP_POP    = 2'd2
	} op_t;

	typedef enum logic [2:0] {
		STAT_OK       = 3'd0,
		STAT_EXISTS   = 3'd1,
		STAT_NO_LIST  = 3'd2,
		STAT_EMPTY    = 3'd3,
		STAT_FULL     = 3'd4
	} status_t;

	typedef struct packed {
		op_t                operation;
		logic [3:0]         list_id;
		logic               make_queue;
		logic signed [31:0] value;
	} cmd_t;

	typedef struct packed {
		status_t            status;
		logic               value_valid;
		logic signed [31:0] popped_value;
	} result_t;

	typedef enum logic {
		S_IDLE = 1'b0,
		S_EXEC = 1'b1
	} ctrl_state_t;

	typedef struct packed {
		logic capture;
		logic execute;
	} ctrl_t;

endpackage

@@ sv/msqm_ctrl.sv @@
// ----------------------------------------------------------------------------
// Multi stack/queue manager controller
// Two-state sequencer: capture a command beat, then execute and answer it.
// ----------------------------------------------------------------------------
module msqm_ctrl (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            start,
	output logic            busy,
	output logic            done,
	output msqm_pkg::ctrl_t ctrl
);

	msqm_pkg::ctrl_state_t state_q;
	msqm_pkg::ctrl_state_t state_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= msqm_pkg::S_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			msqm_pkg::S_IDLE: begin
				if (start) begin
					state_d = msqm_pkg::S_EXEC;
				end
			end
			msqm_pkg::S_EXEC: begin
				state_d = msqm_pkg::S_IDLE;
			end
			default: begin
				state_d = msqm_pkg::S_IDLE;
			end
		endcase
	end

	always_comb begin
		busy         = 1'b0;
		done         = 1'b0;
		ctrl.capture = 1'b0;
		ctrl.execute = 1'b0;
		unique case (state_q)
			msqm_pkg::S_IDLE: begin
				ctrl.capture = start;
			end
			msqm_pkg::S_EXEC: begin
				busy         = 1'b1;
				done         = 1'b1;
				ctrl.execute = 1'b1;
			end
			default: begin
				busy = 1'b0;
			end
		endcase
	end

endmodule

@@ sv/msqm_datapath.sv @@
// ----------------------------------------------------------------------------
// Multi stack/queue manager datapath
// List table, head and tail pointers, node memories and free-node bookkeeping.
// ----------------------------------------------------------------------------
module msqm_datapath #(
	parameter int NUM_LISTS  = 16,
	parameter int POOL_DEPTH = 1024,
	parameter int DATA_WIDTH = 32
) (
	input  logic              clk,
	input  logic              arst_n,
	input  msqm_pkg::ctrl_t   ctrl,
	input  msqm_pkg::cmd_t    cmd,
	output msqm_pkg::result_t result
);

	localparam int LW = (NUM_LISTS > 1) ? $clog2(NUM_LISTS) : 1;
	localparam int PW = $clog2(POOL_DEPTH);
	localparam int FW = $clog2(POOL_DEPTH + 1);

	logic [NUM_LISTS-1:0]  used_q;
	logic [NUM_LISTS-1:0]  queue_q;
	logic [NUM_LISTS-1:0]  empty_q;
	logic [PW-1:0]         head_q [NUM_LISTS];
	logic [PW-1:0]         tail_q [NUM_LISTS];
	logic [DATA_WIDTH-1:0] data_mem [POOL_DEPTH];
	logic [PW-1:0]         link_mem [POOL_DEPTH];

	logic [PW-1:0]         free_head_q;
	logic                  free_valid_q;
	logic [FW-1:0]         fresh_q;

	msqm_pkg::cmd_t        cmd_q;
	logic [DATA_WIDTH-1:0] data_rd_q;
	logic [PW-1:0]         link_rd_q;

	logic [LW-1:0]         in_idx;
	logic                  in_ok;
	logic [PW-1:0]         data_raddr;
	logic [PW-1:0]         link_raddr;

	logic [LW-1:0]         idx;
	logic                  id_ok;
	logic                  used;
	logic [PW-1:0]         head;
	logic [PW-1:0]         tail;
	logic [PW-1:0]         node;

	logic                  data_we;
	logic                  link_we;
	logic [PW-1:0]         link_waddr;
	logic [PW-1:0]         link_wdata;
	logic                  set_used;
	logic                  set_empty;
	logic                  clr_empty;
	logic                  head_we;
	logic [PW-1:0]         head_wdata;
	logic                  tail_we;
	logic [PW-1:0]         free_head_d;
	logic                  free_valid_d;
	logic [FW-1:0]         fresh_d;

	assign in_idx     = LW'(cmd.list_id);
	assign in_ok      = int'(cmd.list_id) < NUM_LISTS;
	assign data_raddr = in_ok ? head_q[in_idx] : free_head_q;
	assign link_raddr = (in_ok && cmd.operation == msqm_pkg::OP_POP) ?
		head_q[in_idx] : free_head_q;

	always_ff @(posedge clk) begin
		if (ctrl.capture) begin
			cmd_q     <= cmd;
			data_rd_q <= data_mem[data_raddr];
			link_rd_q <= link_mem[link_raddr];
		end
		if (ctrl.execute && data_we) begin
			data_mem[node] <= DATA_WIDTH'($unsigned(cmd_q.value));
		end
		if (ctrl.execute && link_we) begin
			link_mem[link_waddr] <= link_wdata;
		end
		if (ctrl.execute && head_we) begin
			head_q[idx] <= head_wdata;
		end
		if (ctrl.execute && tail_we) begin
			tail_q[idx] <= node;
		end
	end

	assign idx   = LW'(cmd_q.list_id);
	assign id_ok = int'(cmd_q.list_id) < NUM_LISTS;
	assign used  = id_ok && used_q[idx];
	assign head  = head_q[idx];
	assign tail  = tail_q[idx];

	always_comb begin
		result.status       = msqm_pkg::STAT_OK;
		result.value_valid  = 1'b0;
		result.popped_value = '0;
		node         = free_head_q;
		data_we      = 1'b0;
		link_we      = 1'b0;
		link_waddr   = head;
		link_wdata   = head;
		set_used     = 1'b0;
		set_empty    = 1'b0;
		clr_empty    = 1'b0;
		head_we      = 1'b0;
		head_wdata   = link_rd_q;
		tail_we      = 1'b0;
		free_head_d  = free_head_q;
		free_valid_d = free_valid_q;
		fresh_d      = fresh_q;
		case (cmd_q.operation)
			msqm_pkg::OP_CREATE: begin
				if (!id_ok) begin
					result.status = msqm_pkg::STAT_NO_LIST;
				end else if (used) begin
					result.status = msqm_pkg::STAT_EXISTS;
				end else begin
					set_used  = 1'b1;
					set_empty = 1'b1;
				end
			end
			msqm_pkg::OP_PUSH: begin
				if (!used) begin
					result.status = msqm_pkg::STAT_NO_LIST;
				end else if (!free_valid_q && int'(fresh_q) >= POOL_DEPTH) begin
					result.status = msqm_pkg::STAT_FULL;
				end else begin
					if (free_valid_q) begin
						node = free_head_q;
						if (link_rd_q == free_head_q) begin
							free_valid_d = 1'b0;
						end else begin
							free_head_d = link_rd_q;
						end
					end else begin
						node    = fresh_q[PW-1:0];
						fresh_d = FW'(fresh_q + 1'b1);
					end
					data_we = 1'b1;
					if (empty_q[idx]) begin
						head_we    = 1'b1;
						head_wdata = node;
						tail_we    = 1'b1;
						clr_empty  = 1'b1;
					end else if (queue_q[idx]) begin
						link_we    = 1'b1;
						link_waddr = tail;
						link_wdata = node;
						tail_we    = 1'b1;
					end else begin
						link_we    = 1'b1;
						link_waddr = node;
						link_wdata = head;
						head_we    = 1'b1;
						head_wdata = node;
					end
				end
			end
			msqm_pkg::OP_POP: begin
				if (!used) begin
					result.status = msqm_pkg::STAT_NO_LIST;
				end else if (empty_q[idx]) begin
					result.status = msqm_pkg::STAT_EMPTY;
				end else begin
					result.value_valid  = 1'b1;
					result.popped_value = 32'(data_rd_q);
					if (head == tail) begin
						set_empty = 1'b1;
					end else begin
						head_we    = 1'b1;
						head_wdata = link_rd_q;
					end
					link_we      = 1'b1;
					link_waddr   = head;
					link_wdata   = free_valid_q ? free_head_q : head;
					free_head_d  = head;
					free_valid_d = 1'b1;
				end
			end
			default: begin
				result.status = msqm_pkg::STAT_OK;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			used_q       <= '0;
			queue_q      <= '0;
			empty_q      <= '1;
			free_head_q  <= '0;
			free_valid_q <= 1'b0;
			fresh_q      <= '0;
		end else if (ctrl.execute) begin
			if (set_used) begin
				used_q[idx]  <= 1'b1;
				queue_q[idx] <= cmd_q.make_queue;
			end
			if (set_empty) begin
				empty_q[idx] <= 1'b1;
			end else if (clr_empty) begin
				empty_q[idx] <= 1'b0;
			end
			free_head_q  <= free_head_d;
			free_valid_q <= free_valid_d;
			fresh_q      <= fresh_d;
		end
	end

endmodule

@@ sv/multi_stack_queue_manager.sv @@
// ----------------------------------------------------------------------------
// Multi stack/queue manager
// Lists of words, each a stack or a queue, sharing one linked node pool.
//
// A command beat (create, push or pop on a list id) is taken on a rising edge
// with start high and busy low. The block then raises busy for one cycle; in
// that cycle done is high and result carries the status and, on a successful
// pop, the popped word. Each command first reads the list pointers and the
// node memories (synchronous reads), then answers and writes back. busy is
// still high at the edge that ends the result cycle, so no new command is
// taken until busy is low again; the block cannot take a new command before
// it has answered the last one.
// The result is shown for exactly one cycle; the receiver cannot stall it.
// Reset clears the list table (no list created, all empty) and the free-node
// state at once; node memories and pointers need no clearing, as they are
// always written before they are read.
// ----------------------------------------------------------------------------
module multi_stack_queue_manager #(
	parameter int NUM_LISTS  = 16,
	parameter int POOL_DEPTH = 1024,
	parameter int DATA_WIDTH = 32
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              start,
	output logic              busy,
	input  msqm_pkg::cmd_t    cmd,
	output logic              done,
	output msqm_pkg::result_t result
);

	msqm_pkg::ctrl_t ctrl;

	msqm_ctrl u_ctrl (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (start),
		.busy   (busy),
		.done   (done),
		.ctrl   (ctrl)
	);

	msqm_datapath #(
		.NUM_LISTS  (NUM_LISTS),
		.POOL_DEPTH (POOL_DEPTH),
		.DATA_WIDTH (DATA_WIDTH)
	) u_datapath (
		.clk    (clk),
		.arst_n (arst_n),
		.ctrl   (ctrl),
		.cmd    (cmd),
		.result (result)
	);

endmodule
